FILE: rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// Page frame allocator package
// Sizes, operation codes and status codes shared by the allocator files.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // Store geometry.
    localparam int MAX_FRAMES   = 1024;
    localparam int PAGE_BYTES   = 4096;
    localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
    localparam int WORD_BITS    = 32;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int MAP_WORDS    = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W       = $clog2(MAP_WORDS);
    localparam int RESET_FRAMES = (1024 > MAX_FRAMES) ? MAX_FRAMES : 1024;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 32;
    localparam int FRAME_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 3;
    localparam int AFRAME_W = ADDR_W - PAGE_SHIFT;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_CLAIM = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_MISALIGNED = 3'd2,
        ST_BADFRAME   = 3'd3,
        ST_DOUBLE     = 3'd4
    } t_status;

endpackage

FILE: rtl/pfa_if.sv
// ----------------------------------------------------------------------------
// Page frame allocator channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------

// Request channel: one allocate, claim or free transaction.
interface pfa_item_if
    import pfa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [ADDR_W-1:0]   address;
    logic [FRAME_W-1:0]  frame;

    modport source (output valid, output operation, output address, output frame,
                    input ready);
    modport sink   (input valid, input operation, input address, input frame,
                    output ready);
endinterface

// Result channel: one status transaction per request.
interface pfa_result_if
    import pfa_pkg::*;
();
    logic                valid;
    logic                ready;
    t_status             status;
    logic [FRAME_W-1:0]  frame_out;
    logic [COUNT_W-1:0]  free_count;

    modport source (output valid, output status, output frame_out, output free_count,
                    input ready);
    modport sink   (input valid, input status, input frame_out, input free_count,
                    output ready);
endinterface

FILE: rtl/pfa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, and read port whose data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/page_frame_allocator.sv
// Sequence: a claim, free or allocate that touches the bitmap reads the word at
// acceptance, modifies and writes it back through the single bitmap memory, then
// loads the result register; a request rejected by decode goes straight to the
// result load. The result load waits while an untaken result is held, and no new request is taken until it is loaded.
// Reset and frame-count writes clear the per-word valid bits and reload the summary;
// an unwritten word reads as its initial pattern, so there is no sweep.
// ----------------------------------------------------------------------------
// Page frame allocator
// Free-frame bitmap in a 32-bit-word RAM with a per-word summary and a free
// counter; serves allocate-highest, claim-by-address and free requests.
// ----------------------------------------------------------------------------
module page_frame_allocator
    import pfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    pfa_item_if.sink           i_item,
    pfa_result_if.source       o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_PUSH
    } t_state;

    // Initial content of one bitmap word for a given frame count.
    function automatic logic [WORD_BITS-1:0] fill_word(logic [WORD_W-1:0] w,
                                                       logic [COUNT_W-1:0] count);
        logic [WORD_BITS-1:0] v;
        v = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            v[b] = (COUNT_W'({w, BIT_W'(b)}) < count);
        end
        return v;
    endfunction

    // Initial summary: a word holds a free frame when its first frame is below count.
    function automatic logic [MAP_WORDS-1:0] fill_sum(logic [COUNT_W-1:0] count);
        logic [MAP_WORDS-1:0] v;
        v = '0;
        for (int w = 0; w < MAP_WORDS; w++) begin
            v[w] = (COUNT_W'({WORD_W'(w), BIT_W'(0)}) < count);
        end
        return v;
    endfunction

    t_state               r_state;
    logic [OP_W-1:0]      r_op;
    logic [WORD_W-1:0]    r_word;
    logic [BIT_W-1:0]     r_bit;
    logic [COUNT_W-1:0]   r_frames;
    logic [COUNT_W-1:0]   r_total;
    logic [MAP_WORDS-1:0] r_valid;
    logic [MAP_WORDS-1:0] r_sum;
    t_status              r_p_status;
    logic [FRAME_W-1:0]   r_p_frame;
    logic                 r_o_valid;
    t_status              r_o_status;
    logic [FRAME_W-1:0]   r_o_frame;
    logic [COUNT_W-1:0]   r_o_count;

    logic                 in_acc;
    logic                 d_read;
    t_status              d_status;
    logic [WORD_W-1:0]    d_word;
    logic [BIT_W-1:0]     d_bit;
    logic [WORD_W-1:0]    hi_word;
    logic [AFRAME_W-1:0]  addr_frame;
    logic [COUNT_W-1:0]   cfg_count;

    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] cur;
    logic [WORD_BITS-1:0] m_new;
    logic [BIT_W-1:0]     hi_bit;
    t_status              m_status;
    logic [FRAME_W-1:0]   m_frame;
    logic [COUNT_W-1:0]   m_total;
    logic                 push_ok;

    assign in_acc         = i_item.valid && (r_state == S_IDLE);
    assign i_item.ready   = (r_state == S_IDLE);
    assign addr_frame     = i_item.address[ADDR_W-1:PAGE_SHIFT];
    assign cfg_count      = (i_cfg_wdata > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES)
                                                                  : i_cfg_wdata;
    assign push_ok        = !r_o_valid || o_result.ready;

    // Highest word that still holds a free frame.
    always_comb begin
        hi_word = '0;
        for (int w = 0; w < MAP_WORDS; w++) begin
            if (r_sum[w]) begin
                hi_word = WORD_W'(w);
            end
        end
    end

    // Request decode: pick the word to read, or reject without a read.
    always_comb begin
        d_read   = 1'b0;
        d_status = ST_OK;
        d_word   = i_item.frame[FRAME_W-1:BIT_W];
        d_bit    = i_item.frame[BIT_W-1:0];
        case (i_item.operation)
            OP_ALLOC: begin
                d_word = hi_word;
                if (r_sum == '0) begin
                    d_status = ST_EMPTY;
                end else begin
                    d_read = 1'b1;
                end
            end
            OP_CLAIM: begin
                d_word = addr_frame[FRAME_W-1:BIT_W];
                d_bit  = addr_frame[BIT_W-1:0];
                if (i_item.address[PAGE_SHIFT-1:0] != '0) begin
                    d_status = ST_MISALIGNED;
                end else if (addr_frame >= AFRAME_W'(r_frames)) begin
                    d_status = ST_BADFRAME;
                end else begin
                    d_read = 1'b1;
                end
            end
            OP_FREE: begin
                if (COUNT_W'(i_item.frame) >= r_frames) begin
                    d_status = ST_BADFRAME;
                end else begin
                    d_read = 1'b1;
                end
            end
            default: begin
                d_status = ST_BADFRAME;
            end
        endcase
    end

    // Bitmap word as stored, or its initial pattern if never written.
    assign cur = r_valid[r_word] ? rd_data : fill_word(r_word, r_frames);

    // Highest free bit of the current word.
    always_comb begin
        hi_bit = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (cur[b]) begin
                hi_bit = BIT_W'(b);
            end
        end
    end

    // Modify step: update the word, counter and result.
    always_comb begin
        m_new    = cur;
        m_status = ST_OK;
        m_frame  = '0;
        m_total  = r_total;
        case (r_op)
            OP_ALLOC: begin
                m_new   = cur & ~(WORD_BITS'(1) << hi_bit);
                m_frame = {r_word, hi_bit};
                m_total = r_total - COUNT_W'(1);
            end
            OP_CLAIM: begin
                if (cur[r_bit]) begin
                    m_new   = cur & ~(WORD_BITS'(1) << r_bit);
                    m_frame = {r_word, r_bit};
                    m_total = r_total - COUNT_W'(1);
                end else begin
                    m_status = ST_BADFRAME;
                end
            end
            OP_FREE: begin
                if (cur[r_bit]) begin
                    m_status = ST_DOUBLE;
                end else begin
                    m_new   = cur | (WORD_BITS'(1) << r_bit);
                    m_frame = {r_word, r_bit};
                    m_total = r_total + COUNT_W'(1);
                end
            end
            default: begin
                m_status = ST_BADFRAME;
            end
        endcase
    end

    // Bitmap store.
    pfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (r_state == S_MOD),
        .i_waddr (r_word),
        .i_wdata (m_new),
        .i_re    (in_acc && d_read),
        .i_raddr (d_word),
        .o_rdata (rd_data)
    );

    // Sequencer, store control state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_frames  <= COUNT_W'(RESET_FRAMES);
            r_total   <= COUNT_W'(RESET_FRAMES);
            r_valid   <= '0;
            r_sum     <= fill_sum(COUNT_W'(RESET_FRAMES));
            r_o_valid <= 1'b0;
        end else begin
            // The held result is dropped once taken, unless a new one replaces it.
            if (r_o_valid && o_result.ready && (r_state != S_PUSH)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op       <= i_item.operation;
                        r_word     <= d_word;
                        r_bit      <= d_bit;
                        r_p_status <= d_status;
                        r_p_frame  <= '0;
                        r_state    <= d_read ? S_MOD : S_PUSH;
                    end
                end
                S_MOD: begin
                    r_valid[r_word] <= 1'b1;
                    r_sum[r_word]   <= (m_new != '0);
                    r_total         <= m_total;
                    r_p_status      <= m_status;
                    r_p_frame       <= m_frame;
                    r_state         <= S_PUSH;
                end
                S_PUSH: begin
                    if (push_ok) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_p_status;
                        r_o_frame  <= r_p_frame;
                        r_o_count  <= r_total;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // A frame-count write re-initializes the store.
            if (i_cfg_we) begin
                r_frames <= cfg_count;
                r_total  <= cfg_count;
                r_valid  <= '0;
                r_sum    <= fill_sum(cfg_count);
            end
        end
    end

    assign o_result.valid      = r_o_valid;
    assign o_result.status     = r_o_status;
    assign o_result.frame_out  = r_o_frame;
    assign o_result.free_count = r_o_count;

    // The free counter never exceeds the number of frames present.
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= r_frames)
        else $error("free count above frame count");

    // The word summary is empty exactly when no frame is free.
    a_sum_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum == '0) == (r_total == '0))
        else $error("word summary disagrees with free count");

    // One request at a time: no new transaction right after an accepted one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_item.ready)
        else $error("request accepted while another is in flight");

    // A failed request never reports a frame.
    a_fail_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status != ST_OK) |-> (o_result.frame_out == '0))
        else $error("frame reported on a failed request");

endmodule
